// File: rtl/core/trk_pkg.sv
// Shared types, constants and tag decode for the tracker module stream parser.
package trk_pkg;

    localparam int unsigned OFF_W = 23;
    localparam logic [OFF_W-1:0] OFF_MAX      = '1;
    localparam logic [OFF_W-1:0] OFF_HDR_LO   = 23'd20;
    localparam logic [OFF_W-1:0] OFF_HDR_HI   = 23'd950;
    localparam logic [OFF_W-1:0] OFF_SONG_LEN = 23'd950;
    localparam logic [OFF_W-1:0] OFF_RESTART  = 23'd951;
    localparam logic [OFF_W-1:0] OFF_ORD_LO   = 23'd952;
    localparam logic [OFF_W-1:0] OFF_TAG_LO   = 23'd1080;
    localparam logic [OFF_W-1:0] OFF_TAG_LAST = 23'd1083;
    localparam logic [OFF_W:0]   PATTERN_BASE = 24'd1084;
    localparam logic [4:0]       HDR_LAST_POS = 5'd29;
    localparam logic [4:0]       HDR_FIELD_LO = 5'd22;
    localparam logic [7:0]       SONG_LEN_MAX = 8'd128;
    localparam int unsigned      Q_DEPTH      = 4;

    typedef enum logic [2:0] {
        K_SAMPLE = 3'd0,
        K_SONG   = 3'd1,
        K_ORDER  = 3'd2,
        K_FORMAT = 3'd3,
        K_CELL   = 3'd4,
        K_DONE   = 3'd5,
        K_ERROR  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_TOO_SMALL = 3'd1,
        E_BAD_TAG   = 3'd2,
        E_BAD_SONG  = 3'd3,
        E_TRUNC     = 3'd4
    } err_t;

    typedef struct packed {
        kind_t             kind;
        err_t              error_code;
        logic [7:0]        index;
        logic [5:0]        row;
        logic [6:0]        channel;
        logic [16:0]       value_a;
        logic [16:0]       value_b;
        logic [16:0]       value_c;
        logic signed [3:0] finetune;
        logic [7:0]        byte_value;
        logic              last_result;
    } res_t;

    // Up to two records per beat, handed from the parser to the output queue.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Channel count from the four tag bytes; zero means unsupported.
    function automatic logic [6:0] tag_channels(input logic [7:0] t0, input logic [7:0] t1,
                                                input logic [7:0] t2, input logic [7:0] t3);
        logic [31:0] w;
        logic [7:0]  v;
        w = {t0, t1, t2, t3};
        v = 8'd0;
        if (w == 32'h4D2E4B2E || w == 32'h4D214B21 || w == 32'h4D264B21 ||
            w == 32'h4E2E542E || w == 32'h464C5434 || w == 32'h3443484E)
            v = 8'd4;
        else if (w == 32'h3643484E)
            v = 8'd6;
        else if (w == 32'h3843484E)
            v = 8'd8;
        else if (is_dig(t0) && t1 == 8'h43 && t2 == 8'h48 && t3 == 8'h4E)
            v = t0 - 8'h30;
        else if (is_dig(t0) && is_dig(t1) && t2 == 8'h43 && t3 == 8'h48)
            v = 8'((t0 - 8'h30) * 8'd10) + (t1 - 8'h30);
        return v[6:0];
    endfunction

endpackage

// File: rtl/core/trk_in_if.sv
// Input byte channel.
interface trk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/core/trk_out_if.sv
// Result record channel.
interface trk_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [2:0]        error_code;
    logic [7:0]        index;
    logic [5:0]        row;
    logic [6:0]        channel;
    logic [16:0]       value_a;
    logic [16:0]       value_b;
    logic [16:0]       value_c;
    logic signed [3:0] finetune;
    logic [7:0]        byte_value;
    logic              last_result;

    modport source (output valid, output kind, output error_code, output index, output row,
                    output channel, output value_a, output value_b, output value_c,
                    output finetune, output byte_value, output last_result, input ready);
    modport sink   (input valid, input kind, input error_code, input index, input row,
                    input channel, input value_a, input value_b, input value_c,
                    input finetune, input byte_value, input last_result, output ready);
endinterface

// File: rtl/core/trk_parse.sv
// Input register, parse state and record build for one byte per cycle while the queue has room.
module trk_parse (
    input  logic              clk,
    input  logic              rst_n,
    trk_in_if.sink            in_ch,
    input  logic              room,
    output trk_pkg::push_t    push
);

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_last_reg;
    logic                       fire;

    logic [trk_pkg::OFF_W-1:0]  off_reg;
    logic [4:0]                 hdr_p_reg, hdr_p_next;
    logic [4:0]                 hdr_h_reg, hdr_h_next;
    logic [7:0]                 song_reg, song_next;
    logic [8:0]                 pat_tot_reg, pat_tot_next;
    logic [6:0]                 ch_tot_reg, ch_tot_next;
    logic [7:0]                 cell_pat_reg, cell_pat_next;
    logic [5:0]                 cell_row_reg, cell_row_next;
    logic [6:0]                 cell_ch_reg, cell_ch_next;
    logic                       err_reg, err_next;

    logic [7:0]                 hdr_mem [0:6];
    logic [7:0]                 tag_mem [0:2];
    logic [7:0]                 cell_mem [0:2];
    logic                       hdr_we, tag_we, cell_we;
    logic [2:0]                 hdr_wa;
    logic [1:0]                 tag_wa, cell_wa;

    logic [15:0]                ch_x_pat;
    logic [trk_pkg::OFF_W:0]    needed;
    logic [trk_pkg::OFF_W:0]    off_ext;
    logic [6:0]                 tag_ch;
    logic [7:0]                 d;
    trk_pkg::res_t              r0, r1, rec, term;
    logic [1:0]                 cnt;
    logic                       have_rec, have_term;

    assign fire        = s1_valid_reg && room;
    assign in_ch.ready = !s1_valid_reg || room;
    assign d           = s1_byte_reg;
    assign ch_x_pat    = 16'(ch_tot_reg * pat_tot_reg);
    assign needed      = trk_pkg::PATTERN_BASE + {ch_x_pat, 8'd0};
    assign off_ext     = {1'b0, off_reg};
    assign tag_ch      = trk_pkg::tag_channels(tag_mem[0], tag_mem[1], tag_mem[2], d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_byte;
        end
    end

    always_comb
    begin
        rec          = '0;
        term         = '0;
        have_rec     = 1'b0;
        have_term    = 1'b0;
        hdr_p_next   = hdr_p_reg;
        hdr_h_next   = hdr_h_reg;
        song_next    = song_reg;
        pat_tot_next = pat_tot_reg;
        ch_tot_next  = ch_tot_reg;
        cell_pat_next = cell_pat_reg;
        cell_row_next = cell_row_reg;
        cell_ch_next = cell_ch_reg;
        err_next     = err_reg;
        hdr_we       = 1'b0;
        hdr_wa       = 3'(hdr_p_reg - trk_pkg::HDR_FIELD_LO);
        tag_we       = 1'b0;
        tag_wa       = off_reg[1:0];
        cell_we      = 1'b0;
        cell_wa      = off_reg[1:0];
        term.kind    = trk_pkg::K_ERROR;
        if (!err_reg)
        begin
            if (off_reg < trk_pkg::OFF_TAG_LAST)
            begin
                if (s1_last_reg)
                begin
                    have_term       = 1'b1;
                    term.error_code = trk_pkg::E_TOO_SMALL;
                    err_next        = 1'b1;
                end
                else if (off_reg >= trk_pkg::OFF_HDR_LO && off_reg < trk_pkg::OFF_HDR_HI)
                begin
                    if (hdr_p_reg == trk_pkg::HDR_LAST_POS)
                    begin
                        hdr_p_next     = 5'd0;
                        hdr_h_next     = hdr_h_reg + 5'd1;
                        have_rec       = 1'b1;
                        rec.kind       = trk_pkg::K_SAMPLE;
                        rec.index      = {3'd0, hdr_h_reg};
                        rec.value_a    = {hdr_mem[0], hdr_mem[1], 1'b0};
                        rec.value_b    = {hdr_mem[4], hdr_mem[5], 1'b0};
                        rec.value_c    = {hdr_mem[6], d, 1'b0};
                        rec.finetune   = hdr_mem[2][3:0];
                        rec.byte_value = hdr_mem[3];
                    end
                    else
                    begin
                        hdr_p_next = hdr_p_reg + 5'd1;
                        hdr_we     = (hdr_p_reg >= trk_pkg::HDR_FIELD_LO);
                    end
                end
                else if (off_reg == trk_pkg::OFF_SONG_LEN)
                begin
                    song_next = d;
                end
                else if (off_reg == trk_pkg::OFF_RESTART)
                begin
                    have_rec       = 1'b1;
                    rec.kind       = trk_pkg::K_SONG;
                    rec.value_a    = {9'd0, song_reg};
                    rec.byte_value = d;
                end
                else if (off_reg >= trk_pkg::OFF_ORD_LO && off_reg < trk_pkg::OFF_TAG_LO)
                begin
                    if ({1'b0, d} + 9'd1 > pat_tot_reg)
                        pat_tot_next = {1'b0, d} + 9'd1;
                    have_rec    = 1'b1;
                    rec.kind    = trk_pkg::K_ORDER;
                    rec.index   = 8'(off_reg - trk_pkg::OFF_ORD_LO);
                    rec.value_a = {9'd0, d};
                end
                else if (off_reg >= trk_pkg::OFF_TAG_LO)
                begin
                    tag_we = 1'b1;
                end
            end
            else if (off_reg == trk_pkg::OFF_TAG_LAST)
            begin
                if (tag_ch == 7'd0)
                begin
                    have_term       = 1'b1;
                    term.error_code = trk_pkg::E_BAD_TAG;
                    err_next        = 1'b1;
                end
                else if (song_reg == 8'd0 || song_reg > trk_pkg::SONG_LEN_MAX)
                begin
                    have_term       = 1'b1;
                    term.error_code = trk_pkg::E_BAD_SONG;
                    err_next        = 1'b1;
                end
                else
                begin
                    ch_tot_next   = tag_ch;
                    cell_pat_next = 8'd0;
                    cell_row_next = 6'd0;
                    cell_ch_next  = 7'd0;
                    have_rec      = 1'b1;
                    rec.kind      = trk_pkg::K_FORMAT;
                    rec.value_a   = {10'd0, tag_ch};
                    rec.value_b   = {8'd0, pat_tot_reg};
                    if (s1_last_reg)
                    begin
                        have_term       = 1'b1;
                        term.error_code = trk_pkg::E_TRUNC;
                        err_next        = 1'b1;
                    end
                end
            end
            else if (off_ext < needed)
            begin
                if (off_reg[1:0] != 2'd3)
                begin
                    cell_we = 1'b1;
                end
                else
                begin
                    have_rec       = 1'b1;
                    rec.kind       = trk_pkg::K_CELL;
                    rec.index      = cell_pat_reg;
                    rec.row        = cell_row_reg;
                    rec.channel    = cell_ch_reg;
                    rec.value_a    = {9'd0, cell_mem[0][7:4], cell_mem[2][7:4]};
                    rec.value_b    = {5'd0, cell_mem[0][3:0], cell_mem[1]};
                    rec.value_c    = {13'd0, cell_mem[2][3:0]};
                    rec.byte_value = d;
                    if (cell_ch_reg + 7'd1 >= ch_tot_reg)
                    begin
                        cell_ch_next  = 7'd0;
                        cell_row_next = cell_row_reg + 6'd1;
                        if (cell_row_reg == 6'd63)
                            cell_pat_next = cell_pat_reg + 8'd1;
                    end
                    else
                    begin
                        cell_ch_next = cell_ch_reg + 7'd1;
                    end
                end
                if (off_ext + 24'd1 == needed)
                begin
                    have_term = 1'b1;
                    term.kind = trk_pkg::K_DONE;
                end
                else if (s1_last_reg)
                begin
                    have_term       = 1'b1;
                    term.error_code = trk_pkg::E_TRUNC;
                    err_next        = 1'b1;
                end
            end
        end
        // order the records of this beat and flag the final one
        r0  = '0;
        r1  = '0;
        cnt = 2'd0;
        if (have_rec && have_term)
        begin
            r0  = rec;
            r1  = term;
            r1.last_result = 1'b1;
            cnt = 2'd2;
        end
        else if (have_rec)
        begin
            r0  = rec;
            r0.last_result = 1'b1;
            cnt = 2'd1;
        end
        else if (have_term)
        begin
            r0  = term;
            r0.last_result = 1'b1;
            cnt = 2'd1;
        end
    end

    assign push.cnt = fire ? cnt : 2'd0;
    assign push.r0  = r0;
    assign push.r1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg      <= '0;
            hdr_p_reg    <= 5'd0;
            hdr_h_reg    <= 5'd0;
            song_reg     <= 8'd0;
            pat_tot_reg  <= 9'd0;
            ch_tot_reg   <= 7'd0;
            cell_pat_reg <= 8'd0;
            cell_row_reg <= 6'd0;
            cell_ch_reg  <= 7'd0;
            err_reg      <= 1'b0;
        end
        else if (fire)
        begin
            if (off_reg != trk_pkg::OFF_MAX)
                off_reg <= off_reg + 23'd1;
            hdr_p_reg    <= hdr_p_next;
            hdr_h_reg    <= hdr_h_next;
            song_reg     <= song_next;
            pat_tot_reg  <= pat_tot_next;
            ch_tot_reg   <= ch_tot_next;
            cell_pat_reg <= cell_pat_next;
            cell_row_reg <= cell_row_next;
            cell_ch_reg  <= cell_ch_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hdr_we)
            hdr_mem[hdr_wa] <= d;
        if (fire && tag_we)
            tag_mem[tag_wa] <= d;
        if (fire && cell_we)
            cell_mem[cell_wa] <= d;
    end

`ifndef ASSERT_OFF
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n) !$fell(err_reg))
        else $error("error latch cleared without reset");
    a_two_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> (push.r1.kind == trk_pkg::K_ERROR || push.r1.kind == trk_pkg::K_DONE))
        else $error("second record of a beat is not terminal");
    a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> push.cnt == 2'd0)
        else $error("records pushed after error");
`endif

endmodule

// File: rtl/core/trk_outq.sv
// Four-entry result queue: takes up to two records per cycle while room is high, drains one.
module trk_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  trk_pkg::push_t push,
    output logic           room,
    trk_out_if.source      out_ch
);

    trk_pkg::res_t q_mem [0:trk_pkg::Q_DEPTH-1];
    logic [1:0]    wr_ptr_reg;
    logic [1:0]    rd_ptr_reg;
    logic [2:0]    count_reg;
    logic          pop;
    trk_pkg::res_t head;

    assign room = (count_reg <= 3'd2);
    assign pop  = out_ch.valid && out_ch.ready;
    assign head = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push.cnt;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, push.cnt} - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            q_mem[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= push.r1;
    end

    assign out_ch.valid       = (count_reg != 3'd0);
    assign out_ch.kind        = head.kind;
    assign out_ch.error_code  = head.error_code;
    assign out_ch.index       = head.index;
    assign out_ch.row         = head.row;
    assign out_ch.channel     = head.channel;
    assign out_ch.value_a     = head.value_a;
    assign out_ch.value_b     = head.value_b;
    assign out_ch.value_c     = head.value_c;
    assign out_ch.finetune    = head.finetune;
    assign out_ch.byte_value  = head.byte_value;
    assign out_ch.last_result = head.last_result;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("push without room");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count moved while idle");
`endif

endmodule

// File: rtl/core/tracker_module_stream_parser_unit.sv
// Top level of the tracker module stream parser.
// Usage:
//   in_ch  : one module file byte per beat (data_byte), last_byte on the final byte.
//   out_ch : result records (sample header, song info, order entry, format, cell,
//            done, error); last_result marks the final record of one input byte.
// Path: the input register takes the byte at the accepting edge; its records are
//   written into the result queue from that register when the queue has room, and
//   out_ch.valid follows from the registered queue count.
// Throughput: one byte per cycle while the queue has room. Each byte yields at most
//   one record except the terminal byte (done or error), which may yield two; after
//   that all bytes are dropped, so a ready receiver never slows the input.
// Records sent before an error are provisional; the consumer drops them.
// Reset: rst_n is async, active low; offset, totals and cell position clear to zero,
//   the queue empties and no record is pending.
// Stall: a four-entry queue parts the two sides; the input keeps flowing while
//   two free slots remain, then in_ch.ready drops until out_ch drains.
// Surplus bytes past the last pattern cell are accepted and ignored.
module tracker_module_stream_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    trk_in_if.sink    in_ch,
    trk_out_if.source out_ch
);

    trk_pkg::push_t push;
    logic           room;

    // byte decode and record build
    trk_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .room  (room),
        .push  (push)
    );

    // record queue toward the receiver
    trk_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

// File: dv/trk_record_checker.sv
// Record checker: watches both channels, predicts parser records and compares them.
module trk_record_checker (
    input  logic clk,
    input  logic rst_n,
    trk_in_if    in_ch,
    trk_out_if   out_ch,
    output int   fail_count,
    output int   records_owed
);

    localparam logic [22:0] OFFSET_TOP = '1;

    trk_pkg::res_t pending_records[$];
    logic [22:0]   offset_now;
    logic [7:0]    hdr_bytes[8];
    logic [7:0]    cell_bytes[3];
    logic [7:0]    tag_bytes[4];
    logic [7:0]    song_len;
    int            pat_total;
    int            chan_total;
    logic [7:0]    at_pattern;
    int            at_row;
    int            at_chan;
    logic          stopped;
    int            mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic trk_pkg::res_t rec(input trk_pkg::kind_t k, input trk_pkg::err_t e,
                                          input int idx, input int r,
                                          input int ch, input int a, input int b, input int c,
                                          input int ft, input int bv);
        trk_pkg::res_t x;
        x.kind        = k;
        x.error_code  = e;
        x.index       = idx[7:0];
        x.row         = r[5:0];
        x.channel     = ch[6:0];
        x.value_a     = a[16:0];
        x.value_b     = b[16:0];
        x.value_c     = c[16:0];
        x.finetune    = ft[3:0];
        x.byte_value  = bv[7:0];
        x.last_result = 1'b0;
        return x;
    endfunction

    function automatic bit dec_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int chans_from_tag(input logic [31:0] w);
        if (w == "M.K." || w == "M!K!" || w == "M&K!" || w == "N.T." ||
            w == "FLT4" || w == "4CHN")
            return 4;
        if (w == "6CHN") return 6;
        if (w == "8CHN") return 8;
        if (dec_char(w[31:24]) && w[23:0] == "CHN")
            return w[31:24] - "0";
        if (dec_char(w[31:24]) && dec_char(w[23:16]) && w[15:0] == "CH")
            return (w[31:24] - "0") * 10 + (w[23:16] - "0");
        return 0;
    endfunction

    // Works out the records one accepted byte produces and queues them.
    task automatic parse_module_byte(input logic [7:0] d, input logic last);
        trk_pkg::res_t recs[2];
        int   n;
        int   off;
        int   rel;
        int   p;
        int   ch;
        int   needed;
        int   k;
        n   = 0;
        off = offset_now;
        if (offset_now != OFFSET_TOP)
            offset_now++;
        if (stopped)
            return;
        if (off < 1083) begin
            if (last) begin
                recs[n++] = rec(trk_pkg::K_ERROR, trk_pkg::E_TOO_SMALL,
                                0, 0, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end else if (off >= 20 && off < 950) begin
                rel = off - 20;
                p   = rel % 30;
                if (p >= 22 && p < 29)
                    hdr_bytes[p - 22] = d;
                else if (p == 29)
                    recs[n++] = rec(trk_pkg::K_SAMPLE, trk_pkg::E_NONE, rel / 30, 0, 0,
                                    {hdr_bytes[0], hdr_bytes[1]} * 2,
                                    {hdr_bytes[4], hdr_bytes[5]} * 2,
                                    {hdr_bytes[6], d} * 2,
                                    hdr_bytes[2][3:0], hdr_bytes[3]);
            end else if (off == 950) begin
                song_len = d;
            end else if (off == 951) begin
                recs[n++] = rec(trk_pkg::K_SONG, trk_pkg::E_NONE,
                                0, 0, 0, song_len, 0, 0, 0, d);
            end else if (off >= 952 && off < 1080) begin
                if (d + 1 > pat_total)
                    pat_total = d + 1;
                recs[n++] = rec(trk_pkg::K_ORDER, trk_pkg::E_NONE,
                                off - 952, 0, 0, d, 0, 0, 0, 0);
            end else if (off >= 1080) begin
                tag_bytes[off - 1080] = d;
            end
        end else if (off == 1083) begin
            tag_bytes[3] = d;
            ch = chans_from_tag({tag_bytes[0], tag_bytes[1], tag_bytes[2], d});
            if (ch == 0) begin
                recs[n++] = rec(trk_pkg::K_ERROR, trk_pkg::E_BAD_TAG,
                                0, 0, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end else if (song_len < 1 || song_len > 128) begin
                recs[n++] = rec(trk_pkg::K_ERROR, trk_pkg::E_BAD_SONG,
                                0, 0, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end else begin
                chan_total = ch;
                at_pattern = 0;
                at_row     = 0;
                at_chan    = 0;
                recs[n++] = rec(trk_pkg::K_FORMAT, trk_pkg::E_NONE,
                                0, 0, 0, ch, pat_total, 0, 0, 0);
                if (last) begin
                    recs[n++] = rec(trk_pkg::K_ERROR, trk_pkg::E_TRUNC,
                                    0, 0, 0, 0, 0, 0, 0, 0);
                    stopped = 1'b1;
                end
            end
        end else begin
            needed = 1084 + 256 * chan_total * pat_total;
            k      = (off - 1084) & 3;
            if (off >= needed)
                return;
            if (k < 3) begin
                cell_bytes[k] = d;
            end else begin
                recs[n++] = rec(trk_pkg::K_CELL, trk_pkg::E_NONE, at_pattern, at_row, at_chan,
                                (cell_bytes[0] & 8'hF0) | (cell_bytes[2] >> 4),
                                {cell_bytes[0][3:0], cell_bytes[1]},
                                cell_bytes[2][3:0], 0, d);
                at_chan++;
                if (at_chan >= chan_total) begin
                    at_chan = 0;
                    at_row++;
                    if (at_row >= 64) begin
                        at_row = 0;
                        at_pattern++;
                    end
                end
            end
            if (off + 1 == needed) begin
                recs[n++] = rec(trk_pkg::K_DONE, trk_pkg::E_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end else if (last) begin
                recs[n++] = rec(trk_pkg::K_ERROR, trk_pkg::E_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end
        end
        if (n > 0)
            recs[n - 1].last_result = 1'b1;
        for (int i = 0; i < n; i++)
            pending_records.push_back(recs[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        trk_pkg::res_t want;
        if (!rst_n) begin
            offset_now = '0;
            song_len   = '0;
            pat_total  = 0;
            chan_total = 0;
            at_pattern = '0;
            at_row     = 0;
            at_chan    = 0;
            stopped    = 1'b0;
            pending_records.delete();
            records_owed = 0;
        end else begin
            // Output side first: a record never leaves in the beat that causes it.
            if (out_ch.valid && out_ch.ready) begin
                if (pending_records.size() == 0) begin
                    report("unexpected record kind", out_ch.kind, -1);
                end else begin
                    want = pending_records.pop_front();
                    if (out_ch.kind !== want.kind)
                        report("kind", out_ch.kind, want.kind);
                    if (out_ch.error_code !== want.error_code)
                        report("error_code", out_ch.error_code, want.error_code);
                    if (out_ch.index !== want.index)
                        report("index", out_ch.index, want.index);
                    if (out_ch.row !== want.row)
                        report("row", out_ch.row, want.row);
                    if (out_ch.channel !== want.channel)
                        report("channel", out_ch.channel, want.channel);
                    if (out_ch.value_a !== want.value_a)
                        report("value_a", out_ch.value_a, want.value_a);
                    if (out_ch.value_b !== want.value_b)
                        report("value_b", out_ch.value_b, want.value_b);
                    if (out_ch.value_c !== want.value_c)
                        report("value_c", out_ch.value_c, want.value_c);
                    if (out_ch.finetune !== want.finetune)
                        report("finetune", out_ch.finetune, want.finetune);
                    if (out_ch.byte_value !== want.byte_value)
                        report("byte_value", out_ch.byte_value, want.byte_value);
                    if (out_ch.last_result !== want.last_result)
                        report("last_result", out_ch.last_result, want.last_result);
                end
            end
            if (in_ch.valid && in_ch.ready)
                parse_module_byte(in_ch.data_byte, in_ch.last_byte);
            records_owed = pending_records.size();
        end
    end

endmodule

// File: dv/tb_tracker_module_stream_parser_unit.sv
// Testbench top: builds one module file, streams it in and gives the verdict.
module tb_tracker_module_stream_parser_unit;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   fail_count;
    int   records_owed;

    // Handshake between sender and receiver for the long hold-off.
    logic hold_request;
    logic hold_done = 1'b0;
    logic burst_mode;

    logic [7:0] file_bytes[$];

    trk_in_if  in_ch();
    trk_out_if out_ch();

    tracker_module_stream_parser_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    trk_record_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .records_owed (records_owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_tracker_module_stream_parser_unit NOT OK");
            $finish;
        end
    end

    // Pick a tag; all are supported, a few map to odd channel counts.
    function automatic logic [31:0] pick_tag();
        case ($urandom_range(0, 11))
            0:  return "M.K.";
            1:  return "M!K!";
            2:  return "M&K!";
            3:  return "N.T.";
            4:  return "FLT4";
            5:  return "4CHN";
            6:  return "6CHN";
            7:  return "8CHN";
            8:  return "1CHN";
            9:  return "2CHN";
            10: return "01CH";
            default: return "03CH";
        endcase
    endfunction

    // Builds the whole byte stream. Ending style:
    //   0 too short, 1 unsupported tag, 2 song length out of range,
    //   3 ends on the tag byte, 4 cut inside the patterns, else complete (+ surplus).
    task automatic build_file();
        int          ending;
        int          npat;
        int          nch;
        int          top_slot;
        int          cut;
        logic [31:0] tag;
        logic [7:0]  song;
        ending = $urandom_range(0, 11);
        npat   = $urandom_range(1, 2);
        // Title, sample headers: raw random bytes, extremes forced into the first two headers.
        for (int i = 0; i < 950; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 42; i < 50; i++)
            file_bytes[i] = 8'hFF;
        for (int i = 72; i < 80; i++)
            file_bytes[i] = 8'h00;
        file_bytes[74] = 8'h08; // most negative finetune
        // Song length: valid range with its edges, or out of range.
        if (ending == 2)
            song = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(129, 255));
        else
            case ($urandom_range(0, 3))
                0:       song = 8'd1;
                1:       song = 8'd128;
                default: song = 8'($urandom_range(1, 128));
            endcase
        file_bytes.push_back(song);
        file_bytes.push_back(8'($urandom_range(0, 255)));
        top_slot = $urandom_range(0, 127);
        for (int i = 0; i < 128; i++)
            file_bytes.push_back(i == top_slot ? 8'(npat - 1) : 8'($urandom_range(0, npat - 1)));
        if (ending == 1)
            tag = ($urandom_range(0, 1) != 0) ? "0CHN" : $urandom;
        else
            tag = pick_tag();
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(tag[i*8 +: 8]);
        nch = 4;
        if (tag[23:0] == "CHN" && tag[31:24] >= "0" && tag[31:24] <= "9")
            nch = tag[31:24] - "0";
        else if (tag[15:0] == "CH")
            nch = (tag[31:24] - "0") * 10 + (tag[23:16] - "0");
        if (ending == 0)
        begin
            cut = $urandom_range(0, 1082);
            while (file_bytes.size() > cut + 1)
                file_bytes.delete(file_bytes.size() - 1);
            return;
        end
        if (ending == 3)
            return;
        if (ending <= 2)
        begin
            for (int i = 0; i < 20; i++)
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < 256 * nch * npat; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        if (ending == 4)
        begin
            cut = $urandom_range(1084, file_bytes.size() - 2);
            while (file_bytes.size() > cut + 1)
                file_bytes.delete(file_bytes.size() - 1);
            return;
        end
        for (int i = $urandom_range(0, 20); i > 0; i--)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // One byte beat: random gap (none in burst mode), then hold valid until accepted.
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = d;
        in_ch.last_byte = last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stall per record outside burst mode, plus one long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ch.ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end
            if (!burst_mode)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int n;
        hold_request    = 1'b0;
        burst_mode      = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        build_file();
        n = file_bytes.size();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            // Stretches with no idling on either side.
            if (i % 128 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            // Let every owed record drain once, mid-header area.
            if (i == 700)
                while (records_owed != 0)
                    @(negedge clk);
            // Order entries give a record per beat: stall the output to fill the queue.
            if (i == 960)
                hold_request = 1'b1;
            send_byte(file_bytes[i], i == n - 1);
        end
        in_ch.valid     = 1'b0;
        in_ch.last_byte = 1'b0;
        while (records_owed != 0 || (hold_request && !hold_done))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_tracker_module_stream_parser_unit OK");
        else
            $display("tb_tracker_module_stream_parser_unit NOT OK");
        $finish;
    end

endmodule
